[sv/rpe_pkg.sv]
// Shared types and constants of the raster pixel expander.
// Used by the front end, the command queue, the back end and the top level.
package rpe_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_DEPTH_MODE     = 2'd2;
    localparam logic [1:0] CFG_PALETTE_ENABLE = 2'd3;

    // Depth mode codes.
    localparam logic [2:0] DEPTH_1BIT  = 3'd0;
    localparam logic [2:0] DEPTH_4BIT  = 3'd1;
    localparam logic [2:0] DEPTH_8BIT  = 3'd2;
    localparam logic [2:0] DEPTH_24BIT = 3'd3;
    localparam logic [2:0] DEPTH_32BIT = 3'd4;

    // Input action codes.
    localparam logic ACT_PALETTE_WRITE = 1'b0;
    localparam logic ACT_IMAGE_BYTE    = 1'b1;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  depth;
        logic        pal_en;
    } t_cfg;

    typedef enum logic [2:0] {
        KIND_PAL_WR,
        KIND_MONO,
        KIND_NIBBLE,
        KIND_BYTE,
        KIND_DIRECT
    } t_kind;

    // One queued command. For a palette write data is {index, red, green, blue};
    // for a gathered pixel it is {extra, red, green, blue}; otherwise the byte.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] data;
        logic [3:0]  npix;
        logic        use_pal;
        logic        last_img;
    } t_qcmd;

endpackage

[sv/rpe_front.sv]
// Front end of the raster pixel expander: accepts items, tracks the raster position
// and turns each pixel-yielding byte into one queued command. Depends on rpe_pkg.
module rpe_front import rpe_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_depth_wr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [7:0]            i_pal_index,
    input  logic [7:0]            i_pal_red,
    input  logic [7:0]            i_pal_green,
    input  logic [7:0]            i_pal_blue,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_q_not_full,
    output logic                  o_push,
    output t_qcmd                 o_cmd,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row
);

    localparam int CW = COORD_BITS + 1;
    localparam int LW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

    logic [COORD_BITS-1:0] r_col, n_col;
    logic [CW-1:0]         r_row, n_row;
    logic [1:0]            r_phase, n_phase;
    logic [23:0]           r_partial, n_partial;
    logic                  r_parity, n_parity;

    logic [LW-1:0] w_ext, h_ext, span;
    logic [CW-1:0] eff_w, eff_h, rem;
    logic          accept, live, pad, done, row_end, gather_done;
    logic [3:0]    npix;
    t_kind         kind;

    assign span  = LW'(1) << COORD_BITS;
    assign w_ext = LW'(i_cfg.width);
    assign h_ext = LW'(i_cfg.height);
    assign eff_w = (i_cfg.width == '0) ? CW'(1) : CW'((w_ext > span) ? span : w_ext);
    assign eff_h = CW'((h_ext > span) ? span : h_ext);

    assign o_ready = i_q_not_full;
    assign accept  = i_valid && i_q_not_full;
    assign done    = r_row >= eff_h;
    assign live    = (i_action == ACT_IMAGE_BYTE) && !done && (i_cfg.depth <= DEPTH_32BIT);
    assign pad     = (r_col == '0) && (r_phase == 2'd0) && r_parity;
    // A column at or past a width that shrank leaves room for one pixel only.
    assign rem     = (CW'(r_col) >= eff_w) ? CW'(1) : eff_w - CW'(r_col);

    always_comb begin
        kind        = KIND_BYTE;
        npix        = 4'd0;
        gather_done = 1'b0;
        unique case (i_cfg.depth)
            DEPTH_1BIT: begin
                kind = KIND_MONO;
                npix = (rem < CW'(8)) ? rem[3:0] : 4'd8;
            end
            DEPTH_4BIT: begin
                kind = KIND_NIBBLE;
                npix = (rem == CW'(1)) ? 4'd1 : 4'd2;
            end
            DEPTH_8BIT: begin
                kind = KIND_BYTE;
                npix = 4'd1;
            end
            DEPTH_24BIT: begin
                kind        = KIND_DIRECT;
                gather_done = r_phase == 2'd2;
                npix        = {3'd0, gather_done};
            end
            DEPTH_32BIT: begin
                kind        = KIND_DIRECT;
                gather_done = r_phase == 2'd3;
                npix        = {3'd0, gather_done};
            end
            default: begin
                kind = KIND_BYTE;
                npix = 4'd0;
            end
        endcase
    end

    // The byte closes its row when it yields exactly the pixels left in the row.
    assign row_end = (npix != 4'd0) && (CW'(npix) == rem);

    always_comb begin
        o_cmd.kind     = kind;
        o_cmd.npix     = npix;
        o_cmd.use_pal  = i_cfg.pal_en;
        o_cmd.last_img = row_end && ((r_row + CW'(1)) >= eff_h);
        o_cmd.data     = {24'd0, i_data_byte};
        if (i_action == ACT_PALETTE_WRITE) begin
            o_cmd.kind = KIND_PAL_WR;
            o_cmd.data = {i_pal_index, i_pal_red, i_pal_green, i_pal_blue};
        end else if (kind == KIND_DIRECT) begin
            if (i_cfg.depth == DEPTH_24BIT) begin
                o_cmd.data = {8'd0, i_data_byte, r_partial[15:0]};
            end else begin
                o_cmd.data = {i_data_byte, r_partial};
            end
        end
    end

    assign o_col  = r_col;
    assign o_row  = r_row[COORD_BITS-1:0];
    assign o_push = accept &&
                    ((i_action == ACT_PALETTE_WRITE) || (live && !pad && npix != 4'd0));

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_phase   = r_phase;
        n_partial = r_partial;
        n_parity  = r_parity;
        if (accept && live) begin
            if (pad) begin
                n_parity = 1'b0;
            end else begin
                n_parity = !r_parity;
                if (kind == KIND_DIRECT && !gather_done) begin
                    n_partial = r_partial | (24'(i_data_byte) << {r_phase, 3'b000});
                    n_phase   = r_phase + 2'd1;
                end else begin
                    n_phase   = 2'd0;
                    n_partial = '0;
                    if (row_end) begin
                        n_col = '0;
                        n_row = r_row + CW'(1);
                    end else begin
                        n_col = r_col + COORD_BITS'(npix);
                    end
                end
            end
        end
        if (i_depth_wr) begin
            n_phase   = 2'd0;
            n_partial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_phase   <= 2'd0;
            r_partial <= '0;
            r_parity  <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_parity  <= n_parity;
        end
    end

endmodule

[sv/rpe_queue.sv]
// Short command queue between the front end and the back end.
// Plain register FIFO; depth is a power of two. Depends on rpe_pkg.
module rpe_queue import rpe_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;

    assign o_not_full = r_cnt != NW'(DEPTH);
    assign o_valid    = r_cnt != '0;
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

[sv/rpe_back.sv]
// Back end of the raster pixel expander: expands queued commands into pixels,
// owns the palette memory and the output register. Depends on rpe_pkg.
module rpe_back import rpe_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_qcmd                 i_cmd,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [23:0]           o_color,
    output logic [7:0]            o_extra,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row,
    output logic                  o_last_run,
    output logic                  o_last_img
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [23:0] r_pal [PALETTE_ENTRIES];
    logic [23:0] r_pal_q;
    logic [2:0]  r_k;

    logic                  r_o_valid, r_o_sel, r_o_ok, r_o_last_run, r_o_last_img;
    logic [23:0]           r_o_color;
    logic [7:0]            r_o_extra;
    logic [COORD_BITS-1:0] r_o_col, r_o_row;

    logic        is_pal, adv, pix_go, last_k, sel_pal, rd_ok, wr_ok;
    logic [7:0]  byte_v, v, grey;
    logic [23:0] color;
    logic [7:0]  extra;

    assign is_pal = i_cmd.kind == KIND_PAL_WR;
    assign adv    = !r_o_valid || i_ready;
    assign pix_go = i_q_valid && !is_pal && adv;
    assign last_k = (4'({1'b0, r_k}) + 4'd1) == i_cmd.npix;
    assign o_q_pop = i_q_valid && (is_pal || (pix_go && last_k));

    assign byte_v = i_cmd.data[7:0];
    assign v      = (i_cmd.kind == KIND_NIBBLE)
                    ? ((r_k == 3'd0) ? {4'd0, byte_v[7:4]} : {4'd0, byte_v[3:0]})
                    : byte_v;
    // A set bit is black, most significant bit first.
    assign grey   = byte_v[~r_k] ? 8'd0 : 8'd255;
    assign rd_ok  = {1'b0, v} < 9'(PALETTE_ENTRIES);
    assign wr_ok  = {1'b0, i_cmd.data[31:24]} < 9'(PALETTE_ENTRIES);

    always_comb begin
        sel_pal = 1'b0;
        extra   = 8'd0;
        case (i_cmd.kind)
            KIND_MONO:   color = {grey, grey, grey};
            KIND_DIRECT: begin
                color = i_cmd.data[23:0];
                extra = i_cmd.data[31:24];
            end
            default: begin
                sel_pal = i_cmd.use_pal;
                color   = {v, v, v};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_q_valid && is_pal && wr_ok) begin
            r_pal[i_cmd.data[AW+23:24]] <= i_cmd.data[23:0];
        end
        if (pix_go) begin
            r_pal_q <= r_pal[v[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_o_sel      <= sel_pal;
            r_o_ok       <= rd_ok;
            r_o_color    <= color;
            r_o_extra    <= extra;
            r_o_col      <= i_col + COORD_BITS'(r_k);
            r_o_row      <= i_row;
            r_o_last_run <= last_k;
            r_o_last_img <= last_k && i_cmd.last_img;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_o_valid <= pix_go;
            end
            if (pix_go) begin
                r_k <= last_k ? 3'd0 : r_k + 3'd1;
            end
        end
    end

    assign o_valid    = r_o_valid;
    assign o_color    = r_o_sel ? (r_o_ok ? r_pal_q : 24'd0) : r_o_color;
    assign o_extra    = r_o_extra;
    assign o_col      = r_o_col;
    assign o_row      = r_o_row;
    assign o_last_run = r_o_last_run;
    assign o_last_img = r_o_last_img;

endmodule

[sv/raster_pixel_expander_top.sv]
// Top level of the raster pixel expander: configuration registers, front end,
// command queue and back end. Depends on rpe_pkg, rpe_front, rpe_queue, rpe_back.

// Turns the pixel bytes of a raster image into one four-byte pixel per output
// item, with its column and row. Each input item is either a palette write or
// one image byte; one input item is taken per cycle while the four-entry
// command queue has room. A byte yields up to eight pixels at 1-bit depth and
// up to two at 4-bit depth, and the output stage sends one pixel per cycle while
// the output is ready, so such bytes can outpace it and the queue back-pressures
// the input once it fills. 8-, 24- and 32-bit data run at one byte per cycle
// while the output is ready. The palette is read as the output register loads.
// With an empty queue and a free output, a pixel passes the queue register and
// then the output register once its byte is accepted. An unwritten palette
// entry reads back an unspecified color. No clearing pass after reset.
module raster_pixel_expander_top import rpe_pkg::*; #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int COORD_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // palette_index, palette_red, palette_green, palette_blue, data_byte
    input  logic [39:0] i_s_tdata,
    // action
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_blue, out_green, out_red, out_extra, column_index, row_index
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,
    // last_of_image
    output logic        o_m_tuser
);

    localparam int QW = $bits(t_qcmd) + 2 * COORD_BITS;

    t_cfg                  r_cfg;
    logic                  depth_wr;
    logic                  push, q_not_full, q_valid, q_pop;
    t_qcmd                 f_cmd, b_cmd;
    logic [COORD_BITS-1:0] f_col, f_row, b_col, b_row, o_col, o_row;
    logic [QW-1:0]         q_in, q_head;
    logic [23:0]           color;
    logic [7:0]            extra;
    logic [31:0]           col_w, row_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 16'd1;
            r_cfg.height <= 16'd1;
            r_cfg.depth  <= DEPTH_8BIT;
            r_cfg.pal_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_WIDTH:    r_cfg.width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_cfg.height <= i_cfg_data;
                CFG_DEPTH_MODE:     r_cfg.depth  <= i_cfg_data[2:0];
                CFG_PALETTE_ENABLE: r_cfg.pal_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign depth_wr = i_cfg_we && (i_cfg_addr == CFG_DEPTH_MODE);

    rpe_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_depth_wr   (depth_wr),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_action     (i_s_tuser),
        .i_pal_index  (i_s_tdata[7:0]),
        .i_pal_red    (i_s_tdata[15:8]),
        .i_pal_green  (i_s_tdata[23:16]),
        .i_pal_blue   (i_s_tdata[31:24]),
        .i_data_byte  (i_s_tdata[39:32]),
        .i_q_not_full (q_not_full),
        .o_push       (push),
        .o_cmd        (f_cmd),
        .o_col        (f_col),
        .o_row        (f_row)
    );

    assign q_in = {f_row, f_col, f_cmd};

    rpe_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (q_in),
        .o_not_full (q_not_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    assign b_cmd = q_head[$bits(t_qcmd)-1:0];
    assign b_col = q_head[$bits(t_qcmd) +: COORD_BITS];
    assign b_row = q_head[$bits(t_qcmd) + COORD_BITS +: COORD_BITS];

    rpe_back #(
        .COORD_BITS      (COORD_BITS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (b_cmd),
        .i_col      (b_col),
        .i_row      (b_row),
        .o_q_pop    (q_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_color    (color),
        .o_extra    (extra),
        .o_col      (o_col),
        .o_row      (o_row),
        .o_last_run (o_m_tlast),
        .o_last_img (o_m_tuser)
    );

    assign col_w     = 32'(o_col);
    assign row_w     = 32'(o_row);
    assign o_m_tdata = {row_w[15:0], col_w[15:0], extra, color};

`ifndef SYNTHESIS
    // The last pixel of the image is always the last pixel of its byte.
    a_img_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("last_of_image without last_of_run");

    // The back end never retires a command that is not there.
    a_pop_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // An empty queue always leaves the input open.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_valid |-> o_s_tready)
        else $error("input stalled with an empty queue");
`endif

endmodule

[dv/rpe_pixel_checker.sv]
// Scoreboard for the raster pixel expander: mirrors the configuration port,
// predicts the pixels of every accepted input item and checks each output item.
// Depends on rpe_pkg for the register indexes, depth codes and action codes.
module rpe_pixel_checker import rpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,
    output logic [31:0] o_mismatches,
    output logic [31:0] o_pending,
    output logic [31:0] o_rows_done
);

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  extra;
        logic [15:0] column;
        logic [15:0] row;
        logic        last_run;
        logic        last_img;
    } t_pixel;

    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [2:0]  depth;
    logic        pal_on;
    logic [23:0] palette [256];

    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned byte_phase;
    logic [23:0] partial;
    logic        odd_row_bytes;

    t_pixel      pending_pixels [$];
    t_pixel      burst [8];
    int          burst_len;
    int unsigned mismatches = 0;
    int unsigned owed = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = owed;
    assign o_rows_done  = row_cnt;

    // Appends one pixel to the current burst and advances the raster position.
    // Returns 1 when the pixel closes its row.
    function automatic logic put_pixel(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r, input logic [7:0] e);
        t_pixel      px;
        int unsigned span;
        logic        row_end;
        span = (img_width == 16'd0) ? 1 : 32'(img_width);
        px.blue     = b;
        px.green    = g;
        px.red      = r;
        px.extra    = e;
        px.column   = col_cnt[15:0];
        px.row      = row_cnt[15:0];
        px.last_run = 1'b0;
        px.last_img = 1'b0;
        row_end     = 1'b0;
        if (col_cnt + 1 >= span) begin
            col_cnt = 0;
            row_cnt++;
            row_end = 1'b1;
            if (row_cnt >= 32'(img_height))
                px.last_img = 1'b1;
        end else begin
            col_cnt++;
        end
        burst[burst_len] = px;
        burst_len++;
        return row_end;
    endfunction

    function automatic logic put_mapped(input logic [7:0] v);
        logic [23:0] c;
        c = pal_on ? palette[v] : {v, v, v};
        return put_pixel(c[7:0], c[15:8], c[23:16], 8'd0);
    endfunction

    task automatic expand_item(input logic act, input logic [39:0] payload);
        logic [7:0] d;
        logic [7:0] level;
        logic       row_done;
        int         i;
        d         = payload[39:32];
        burst_len = 0;
        if (act == ACT_PALETTE_WRITE) begin
            palette[payload[7:0]] = {payload[15:8], payload[23:16], payload[31:24]};
        end else if (row_cnt < 32'(img_height) && depth <= DEPTH_32BIT) begin
            if (col_cnt == 0 && byte_phase == 0 && odd_row_bytes) begin
                // Pad byte after a row with an odd byte count: dropped.
                odd_row_bytes = 1'b0;
            end else begin
                odd_row_bytes = ~odd_row_bytes;
                case (depth)
                    DEPTH_1BIT: begin
                        row_done = 1'b0;
                        for (i = 7; i >= 0 && !row_done; i--) begin
                            level    = d[i] ? 8'd0 : 8'd255;
                            row_done = put_pixel(level, level, level, 8'd0);
                        end
                    end
                    DEPTH_4BIT: begin
                        // The low nibble is lost when the high one ends the row.
                        if (!put_mapped({4'd0, d[7:4]}))
                            void'(put_mapped({4'd0, d[3:0]}));
                    end
                    DEPTH_8BIT: begin
                        void'(put_mapped(d));
                    end
                    DEPTH_24BIT: begin
                        if (byte_phase < 2) begin
                            partial = partial | ({16'd0, d} << (8 * byte_phase));
                            byte_phase++;
                        end else begin
                            void'(put_pixel(partial[7:0], partial[15:8], d, 8'd0));
                            byte_phase = 0;
                            partial    = '0;
                        end
                    end
                    default: begin
                        if (byte_phase < 3) begin
                            partial = partial | ({16'd0, d} << (8 * byte_phase));
                            byte_phase++;
                        end else begin
                            void'(put_pixel(partial[7:0], partial[15:8], partial[23:16], d));
                            byte_phase = 0;
                            partial    = '0;
                        end
                    end
                endcase
            end
        end
        if (burst_len > 0)
            burst[burst_len - 1].last_run = 1'b1;
        for (i = 0; i < burst_len; i++)
            pending_pixels.push_back(burst[i]);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (!i_rst_n) begin
            img_width     = 16'd1;
            img_height    = 16'd1;
            depth         = DEPTH_8BIT;
            pal_on        = 1'b0;
            col_cnt       = 0;
            row_cnt       = 0;
            byte_phase    = 0;
            partial       = '0;
            odd_row_bytes = 1'b0;
            pending_pixels.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected pixel, expected none, actual %h", $time,
                             i_m_tdata);
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("out_blue", 16'(want.blue), 16'(i_m_tdata[7:0]));
                    check_field("out_green", 16'(want.green), 16'(i_m_tdata[15:8]));
                    check_field("out_red", 16'(want.red), 16'(i_m_tdata[23:16]));
                    check_field("out_extra", 16'(want.extra), 16'(i_m_tdata[31:24]));
                    check_field("column_index", want.column, i_m_tdata[47:32]);
                    check_field("row_index", want.row, i_m_tdata[63:48]);
                    check_field("last_of_run", 16'(want.last_run), 16'(i_m_tlast));
                    check_field("last_of_image", 16'(want.last_img), 16'(i_m_tuser));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_IMAGE_WIDTH:    img_width = i_cfg_data;
                    CFG_IMAGE_HEIGHT:   img_height = i_cfg_data;
                    CFG_DEPTH_MODE: begin
                        depth      = i_cfg_data[2:0];
                        byte_phase = 0;
                        partial    = '0;
                    end
                    CFG_PALETTE_ENABLE: pal_on = i_cfg_data[0];
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expand_item(i_s_tuser, i_s_tdata);
        end
        owed = pending_pixels.size();
    end

endmodule

[dv/raster_pixel_expander_top_test.sv]
// Testbench top for raster_pixel_expander_top: clock, reset, configuration,
// input stream and output back-pressure. Depends on rpe_pkg and rpe_pixel_checker.
module raster_pixel_expander_top_test;
    import rpe_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 160;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    logic [31:0] mismatches;
    logic [31:0] pixels_owed;
    logic [31:0] rows_done;

    int          gap_pct;
    int          stall_pct;
    bit          quiet;
    bit          pal_written [256];
    logic [2:0]  cur_depth;
    logic        cur_pal;

    raster_pixel_expander_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    rpe_pixel_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pixels_owed),
        .o_rows_done  (rows_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Output back-pressure in random bursts.
    initial begin : sink
        int hold;
        hold = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0 && !quiet && $urandom_range(0, 99) < stall_pct)
                hold = $urandom_range(1, 12);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic act, input logic [39:0] payload);
        int gap;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= payload;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [23:0] color);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(ACT_PALETTE_WRITE, {junk, color[7:0], color[15:8], color[23:16], idx});
        pal_written[idx] = 1'b1;
    endtask

    task automatic ensure_entry(input logic [7:0] idx);
        if (!pal_written[idx])
            write_entry(idx, 24'($urandom()));
    endtask

    // Sends one image byte; palette lookups only ever hit written entries.
    task automatic send_raster_byte(input logic [7:0] d);
        logic [31:0] junk;
        junk = $urandom();
        if (cur_pal && cur_depth == DEPTH_4BIT) begin
            ensure_entry({4'd0, d[7:4]});
            ensure_entry({4'd0, d[3:0]});
        end else if (cur_pal && cur_depth == DEPTH_8BIT) begin
            ensure_entry(d);
        end
        send_item(ACT_IMAGE_BYTE, {d, junk});
    endtask

    // Holds the input until every expected pixel is out and the queue is empty.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] width, input logic [15:0] height,
                             input logic [2:0] dm, input logic pal, input bit write_depth);
        set_reg(CFG_IMAGE_WIDTH, width);
        set_reg(CFG_IMAGE_HEIGHT, height);
        if (write_depth) begin
            set_reg(CFG_DEPTH_MODE, {13'd0, dm});
            cur_depth = dm;
        end
        set_reg(CFG_PALETTE_ENABLE, {15'd0, pal});
        i_cfg_we <= 1'b0;
        cur_pal = pal;
    endtask

    initial begin : stimulus
        int         sent;
        int         n;
        int         w;
        int         rows;
        int         i;
        int         waited;
        logic [2:0] dm;
        bit         write_depth;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= CFG_IMAGE_WIDTH;
        i_cfg_data <= 16'd0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= ACT_IMAGE_BYTE;
        i_s_tdata  <= 40'd0;
        quiet      = 1'b0;
        gap_pct    = 20;
        stall_pct  = 20;
        cur_depth  = DEPTH_8BIT;
        cur_pal    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // At reset the image is one 8-bit pixel; the next byte finds it complete.
        send_raster_byte(8'h00);
        send_raster_byte(8'hFF);
        drain();
        configure(16'd1, 16'd0, DEPTH_8BIT, 1'b0, 1'b1);
        send_raster_byte(8'h81);

        // Palette at the index extremes, then two one-pixel rows of zero width.
        write_entry(8'h00, 24'h000000);
        write_entry(8'hFF, 24'hFFFFFF);
        write_entry(8'h5A, 24'h123456);
        drain();
        configure(16'd0, 16'(rows_done + 32'd2), DEPTH_8BIT, 1'b1, 1'b0);
        send_raster_byte(8'h5A);
        send_raster_byte(8'hFF);
        send_raster_byte(8'h00);
        send_raster_byte(8'h00);

        // 1-bit rows that end in the middle of a byte.
        drain();
        configure(16'd3, 16'(rows_done + 32'd1), DEPTH_1BIT, 1'b0, 1'b1);
        send_raster_byte(8'h00);
        send_raster_byte(8'hA5);

        // Full-size settings: whole 1-bit bytes, palette setting has no effect.
        drain();
        configure(16'hFFFF, 16'hFFFF, DEPTH_1BIT, 1'b1, 1'b0);
        send_raster_byte(8'hFF);
        send_raster_byte(8'h00);

        // Width shrinks below the current column; the row closes at once.
        drain();
        configure(16'd3, 16'(rows_done + 32'd2), DEPTH_4BIT, 1'b1, 1'b1);
        send_raster_byte(8'h0F);
        send_raster_byte(8'hF0);
        send_raster_byte(8'h3C);

        drain();
        configure(16'd1, 16'(rows_done + 32'd2), DEPTH_24BIT, 1'b0, 1'b1);
        send_raster_byte(8'h00);
        send_raster_byte(8'hFF);
        send_raster_byte(8'h80);

        // Unknown depth code: bytes are ignored.
        drain();
        configure(16'd1, 16'(rows_done + 32'd2), 3'd7, 1'b0, 1'b1);
        send_raster_byte(8'h7E);

        // A depth write drops a half-gathered pixel.
        drain();
        configure(16'd1, 16'(rows_done + 32'd2), DEPTH_24BIT, 1'b0, 1'b1);
        send_raster_byte(8'h11);
        send_raster_byte(8'h22);
        drain();
        configure(16'd1, 16'(rows_done + 32'd2), DEPTH_32BIT, 1'b0, 1'b1);
        send_raster_byte(8'hFF);
        send_raster_byte(8'h00);
        send_raster_byte(8'h7F);
        send_raster_byte(8'h80);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 50;
            endcase
            if (sent > RANDOM_ITEMS * 85 / 100)
                quiet = 1'b1;

            write_depth = ($urandom_range(0, 3) != 0);
            if (!write_depth)
                dm = cur_depth;
            else if ($urandom_range(0, 19) == 0)
                dm = 3'($urandom_range(5, 7));
            else
                dm = 3'($urandom_range(0, 4));
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = 65535;
                default: w = $urandom_range(1, (dm == DEPTH_24BIT || dm == DEPTH_32BIT) ? 4 : 12);
            endcase
            rows = $urandom_range(1, 3);

            // Bytes for the rows asked for, pads and a few spare; over 40, 6 to 40.
            case (dm)
                DEPTH_1BIT:  n = (w + 7) / 8;
                DEPTH_4BIT:  n = (w + 1) / 2;
                DEPTH_8BIT:  n = w;
                DEPTH_24BIT: n = 3 * w;
                DEPTH_32BIT: n = 4 * w;
                default:     n = 4;
            endcase
            if (n == 0)
                n = 1;
            n = rows * (n + n % 2) + $urandom_range(0, 3);
            if (n > 40)
                n = $urandom_range(6, 40);

            drain();
            configure(w[15:0], 16'(rows_done + 32'(rows)), dm, 1'($urandom_range(0, 1)),
                      write_depth);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    write_entry(8'($urandom_range(0, 255)), 24'($urandom()));
                else
                    send_raster_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pixels_owed != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && pixels_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
